/* rtl/range_add_range_sum_tree_macros.svh */
// ---------------------------------------------------------------------------
// Range add / range sum tree assertion macros
// Concurrent check wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef RANGE_ADD_RANGE_SUM_TREE_MACROS_SVH
`define RANGE_ADD_RANGE_SUM_TREE_MACROS_SVH

`ifndef SYNTHESIS
`define RAST_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RAST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RAST_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RAST_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/rast_pkg.sv */
// ---------------------------------------------------------------------------
// Range add / range sum tree package
// Shared codes and the command / status bundles between control and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package rast_pkg;

   typedef enum logic [1:0] {
      ACT_SET  = 2'd0,
      ACT_ADD  = 2'd1,
      ACT_SUM  = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   // how a stacked frame was left
   typedef enum logic [1:0] {
      PH_SINGLE = 2'd0,
      PH_LEFT   = 2'd1,
      PH_RIGHT  = 2'd2
   } phase_type;

   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_CLEAR,
      CMD_LOAD,
      CMD_RD_NODE,
      CMD_TERM_MUL,
      CMD_TERM_ADD,
      CMD_TERM_SET,
      CMD_TERM_SUM,
      CMD_PUSH_START,
      CMD_PL_WR,
      CMD_PR_RD,
      CMD_PR_WR,
      CMD_PZ,
      CMD_DESC,
      CMD_POP,
      CMD_GO_RIGHT,
      CMD_PU_L,
      CMD_PU_R,
      CMD_PU_W
   } cmd_type;

   typedef struct packed {
      logic       full_cover;
      logic       tag_nz;
      logic       stack_empty;
      logic       phase_left;
      logic       clear_last;
      logic       item_ok;
      action_type op;
   } status_type;

endpackage

`default_nettype wire

/* rtl/rast_dp.sv */
// ---------------------------------------------------------------------------
// Range add / range sum tree datapath
// Node memories, frame registers, return stack, multiplier and accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

module rast_dp #(
   parameter int MAX_POSITIONS = 1024,
   parameter int VALUE_WIDTH   = 64,
   localparam int LEN_W  = $clog2(MAX_POSITIONS + 1),
   localparam int LO_W   = $clog2(MAX_POSITIONS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rast_pkg::cmd_type        cmd,
   output rast_pkg::status_type     status,
   input  logic                     csr_wr_en,
   input  logic [LEN_W-1:0]         csr_wr_data,
   input  logic [1:0]               req_action,
   input  logic [LO_W-1:0]          req_range_low,
   input  logic [LEN_W-1:0]         req_range_high,
   input  logic signed [63:0]       req_operand_value,
   output logic signed [63:0]       rsp_range_sum
);

   localparam int SLOTS  = 4 * MAX_POSITIONS;
   localparam int NODE_W = $clog2(SLOTS);
   localparam int SD     = $clog2(MAX_POSITIONS) + 1;
   localparam int IDX_W  = $clog2(SD);
   localparam int SP_W   = $clog2(SD + 1);
   localparam int VW     = VALUE_WIDTH;

   typedef struct packed {
      logic [NODE_W-1:0]   node;
      logic [LEN_W-1:0]    lo;
      logic [LEN_W-1:0]    hi;
      logic [LEN_W-1:0]    ql;
      logic [LEN_W-1:0]    qh;
      rast_pkg::phase_type ph;
   } frame_type;

   logic [VW-1:0]     sum_mem [SLOTS];
   logic [VW-1:0]     tag_mem [SLOTS];
   frame_type         stk_ff  [SD];

   logic [LEN_W-1:0]  len_ff, len_in;
   logic [NODE_W-1:0] clr_ff;
   logic [SP_W-1:0]   sp_ff;
   frame_type         fr_ff;
   rast_pkg::phase_type ph_ff;
   rast_pkg::action_type op_ff;
   logic [VW-1:0]     val_ff, t_ff, hold_ff, prod_ff, acc_ff;
   logic [VW-1:0]     rd_sum_ff, rd_tag_ff;

   logic [NODE_W-1:0] left_node, right_node, addr;
   logic [LEN_W-1:0]  mid, lo_ext;
   logic              re, we_sum, we_tag;
   logic [VW-1:0]     wsum, wtag, mul_a;
   logic [LEN_W-1:0]  mul_b;
   logic [VW+LEN_W-1:0] mul_full;
   logic [SP_W-1:0]   sp_dec;
   frame_type         top_fr;
   frame_type         push_fr;

   assign left_node  = {fr_ff.node[NODE_W-2:0], 1'b0};
   assign right_node = {fr_ff.node[NODE_W-2:0], 1'b1};
   assign mid        = fr_ff.lo + ((fr_ff.hi - fr_ff.lo) >> 1);
   assign lo_ext     = LEN_W'(req_range_low);
   assign sp_dec     = sp_ff - SP_W'(1);
   assign top_fr     = stk_ff[sp_dec[IDX_W-1:0]];

   // frame as stacked, tagged with the way it is left
   always_comb begin
      push_fr    = fr_ff;
      push_fr.ph = rast_pkg::PH_SINGLE;
      if (cmd == rast_pkg::CMD_GO_RIGHT)
         push_fr.ph = rast_pkg::PH_RIGHT;
      else if ((fr_ff.qh > mid) && (fr_ff.ql < mid))
         push_fr.ph = rast_pkg::PH_LEFT;
   end

   // written length 0 reads as 1, anything past the tree size as the tree size
   always_comb begin
      len_in = csr_wr_data;
      if (csr_wr_data == '0)
         len_in = LEN_W'(1);
      else if (csr_wr_data > LEN_W'(MAX_POSITIONS))
         len_in = LEN_W'(MAX_POSITIONS);
   end

   always_comb begin
      status.full_cover  = (fr_ff.lo == fr_ff.ql) && (fr_ff.hi == fr_ff.qh);
      status.tag_nz      = (rd_tag_ff != '0);
      status.stack_empty = (sp_ff == '0);
      status.phase_left  = (ph_ff == rast_pkg::PH_LEFT);
      status.clear_last  = (clr_ff == NODE_W'(SLOTS - 1));
      status.op          = op_ff;
      unique case (rast_pkg::action_type'(req_action))
         rast_pkg::ACT_SET: status.item_ok = (lo_ext < len_ff);
         rast_pkg::ACT_ADD,
         rast_pkg::ACT_SUM: status.item_ok = (lo_ext < req_range_high) &&
                                             (req_range_high <= len_ff);
         default:           status.item_ok = 1'b0;
      endcase
   end

   always_comb begin
      addr   = fr_ff.node;
      re     = 1'b0;
      we_sum = 1'b0;
      we_tag = 1'b0;
      wsum   = rd_sum_ff + prod_ff;
      wtag   = rd_tag_ff + t_ff;
      mul_a  = t_ff;
      mul_b  = fr_ff.hi - mid;
      case (cmd)
         rast_pkg::CMD_CLEAR: begin
            addr   = clr_ff;
            we_sum = 1'b1;
            we_tag = 1'b1;
            wsum   = '0;
            wtag   = '0;
         end
         rast_pkg::CMD_RD_NODE: re = 1'b1;
         rast_pkg::CMD_TERM_MUL: begin
            mul_a = val_ff;
            mul_b = fr_ff.hi - fr_ff.lo;
         end
         rast_pkg::CMD_TERM_ADD: begin
            we_sum = 1'b1;
            we_tag = 1'b1;
            wtag   = rd_tag_ff + val_ff;
         end
         rast_pkg::CMD_TERM_SET: begin
            we_sum = 1'b1;
            wsum   = val_ff;
         end
         rast_pkg::CMD_PUSH_START: begin
            addr  = left_node;
            re    = 1'b1;
            mul_a = rd_tag_ff;
            mul_b = mid - fr_ff.lo;
         end
         rast_pkg::CMD_PL_WR: begin
            addr   = left_node;
            we_sum = 1'b1;
            we_tag = 1'b1;
         end
         rast_pkg::CMD_PR_RD: begin
            addr = right_node;
            re   = 1'b1;
         end
         rast_pkg::CMD_PR_WR: begin
            addr   = right_node;
            we_sum = 1'b1;
            we_tag = 1'b1;
         end
         rast_pkg::CMD_PZ: begin
            we_tag = 1'b1;
            wtag   = '0;
         end
         rast_pkg::CMD_PU_L: begin
            addr = left_node;
            re   = 1'b1;
         end
         rast_pkg::CMD_PU_R: begin
            addr = right_node;
            re   = 1'b1;
         end
         rast_pkg::CMD_PU_W: begin
            we_sum = 1'b1;
            wsum   = hold_ff + rd_sum_ff;
         end
         default: ;
      endcase
   end

   assign mul_full = {{LEN_W{1'b0}}, mul_a} * {{VW{1'b0}}, mul_b};

   always_ff @(posedge clock) begin
      if (we_sum)
         sum_mem[addr] <= wsum;
      if (we_tag)
         tag_mem[addr] <= wtag;
      if (re) begin
         rd_sum_ff <= sum_mem[addr];
         rd_tag_ff <= tag_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(MAX_POSITIONS);
         clr_ff <= '0;
         sp_ff  <= '0;
      end else begin
         if (csr_wr_en)
            len_ff <= len_in;
         if (csr_wr_en)
            clr_ff <= '0;
         else if (cmd == rast_pkg::CMD_CLEAR)
            clr_ff <= status.clear_last ? '0 : clr_ff + NODE_W'(1);
         case (cmd)
            rast_pkg::CMD_LOAD:     sp_ff <= '0;
            rast_pkg::CMD_DESC,
            rast_pkg::CMD_GO_RIGHT: sp_ff <= sp_ff + SP_W'(1);
            rast_pkg::CMD_POP:      sp_ff <= sp_dec;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         rast_pkg::CMD_LOAD: begin
            fr_ff.node <= NODE_W'(1);
            fr_ff.lo   <= '0;
            fr_ff.hi   <= len_ff;
            fr_ff.ql   <= lo_ext;
            fr_ff.qh   <= (rast_pkg::action_type'(req_action) == rast_pkg::ACT_SET) ?
                          lo_ext + LEN_W'(1) : req_range_high;
            fr_ff.ph   <= rast_pkg::PH_SINGLE;
            op_ff      <= rast_pkg::action_type'(req_action);
            val_ff     <= req_operand_value[VW-1:0];
            acc_ff     <= '0;
         end
         rast_pkg::CMD_TERM_MUL,
         rast_pkg::CMD_PR_RD:    prod_ff <= mul_full[VW-1:0];
         rast_pkg::CMD_PUSH_START: begin
            prod_ff <= mul_full[VW-1:0];
            t_ff    <= rd_tag_ff;
         end
         rast_pkg::CMD_TERM_SUM: acc_ff  <= acc_ff + rd_sum_ff;
         rast_pkg::CMD_PU_R:     hold_ff <= rd_sum_ff;
         rast_pkg::CMD_DESC: begin
            stk_ff[sp_ff[IDX_W-1:0]] <= push_fr;
            if (fr_ff.qh <= mid) begin
               fr_ff.node <= left_node;
               fr_ff.hi   <= mid;
            end else if (fr_ff.ql >= mid) begin
               fr_ff.node <= right_node;
               fr_ff.lo   <= mid;
            end else begin
               fr_ff.node <= left_node;
               fr_ff.hi   <= mid;
               fr_ff.qh   <= mid;
            end
         end
         rast_pkg::CMD_GO_RIGHT: begin
            stk_ff[sp_ff[IDX_W-1:0]] <= push_fr;
            fr_ff.node <= right_node;
            fr_ff.lo   <= mid;
            fr_ff.ql   <= mid;
         end
         rast_pkg::CMD_POP: begin
            fr_ff <= top_fr;
            ph_ff <= top_fr.ph;
         end
         default: ;
      endcase
   end

   assign rsp_range_sum = 64'($signed(acc_ff));

endmodule

`default_nettype wire

/* rtl/rast_ctrl.sv */
// ---------------------------------------------------------------------------
// Range add / range sum tree controller
// Walks the tree: descend with tag push, unwind the stack with pull-up.
// ---------------------------------------------------------------------------
`default_nettype none

module rast_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_action,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rast_pkg::cmd_type     cmd,
   input  rast_pkg::status_type  status
);

   typedef enum logic [14:0] {
      S_CLEAR  = 15'b000000000000001,
      S_IDLE   = 15'b000000000000010,
      S_VISIT  = 15'b000000000000100,
      S_NODE   = 15'b000000000001000,
      S_TADD   = 15'b000000000010000,
      S_PL_WR  = 15'b000000000100000,
      S_PR_RD  = 15'b000000001000000,
      S_PR_WR  = 15'b000000010000000,
      S_PZ     = 15'b000000100000000,
      S_DESC   = 15'b000001000000000,
      S_RET    = 15'b000010000000000,
      S_POPPED = 15'b000100000000000,
      S_PU_R   = 15'b001000000000000,
      S_PU_W   = 15'b010000000000000,
      S_OUT    = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      is_sum;

   assign is_sum    = (status.op == rast_pkg::ACT_SUM);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      cmd      = rast_pkg::CMD_NOP;
      unique case (state_ff)
         S_CLEAR: begin
            cmd = rast_pkg::CMD_CLEAR;
            if (status.clear_last)
               state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd = rast_pkg::CMD_LOAD;
               if (status.item_ok)
                  state_in = S_VISIT;
               else if (rast_pkg::action_type'(req_action) == rast_pkg::ACT_SUM)
                  state_in = S_OUT;
            end
         end
         S_VISIT: begin
            cmd      = rast_pkg::CMD_RD_NODE;
            state_in = S_NODE;
         end
         S_NODE: begin
            if (status.full_cover) begin
               state_in = S_RET;
               case (status.op)
                  rast_pkg::ACT_ADD: begin
                     cmd      = rast_pkg::CMD_TERM_MUL;
                     state_in = S_TADD;
                  end
                  rast_pkg::ACT_SET: cmd = rast_pkg::CMD_TERM_SET;
                  default:           cmd = rast_pkg::CMD_TERM_SUM;
               endcase
            end else if (status.tag_nz) begin
               cmd      = rast_pkg::CMD_PUSH_START;
               state_in = S_PL_WR;
            end else begin
               cmd      = rast_pkg::CMD_DESC;
               state_in = S_VISIT;
            end
         end
         S_TADD: begin
            cmd      = rast_pkg::CMD_TERM_ADD;
            state_in = S_RET;
         end
         S_PL_WR: begin
            cmd      = rast_pkg::CMD_PL_WR;
            state_in = S_PR_RD;
         end
         S_PR_RD: begin
            cmd      = rast_pkg::CMD_PR_RD;
            state_in = S_PR_WR;
         end
         S_PR_WR: begin
            cmd      = rast_pkg::CMD_PR_WR;
            state_in = S_PZ;
         end
         S_PZ: begin
            cmd      = rast_pkg::CMD_PZ;
            state_in = S_DESC;
         end
         S_DESC: begin
            cmd      = rast_pkg::CMD_DESC;
            state_in = S_VISIT;
         end
         S_RET: begin
            if (status.stack_empty)
               state_in = is_sum ? S_OUT : S_IDLE;
            else begin
               cmd      = rast_pkg::CMD_POP;
               state_in = S_POPPED;
            end
         end
         S_POPPED: begin
            if (status.phase_left) begin
               cmd      = rast_pkg::CMD_GO_RIGHT;
               state_in = S_VISIT;
            end else if (is_sum)
               state_in = S_RET;
            else begin
               cmd      = rast_pkg::CMD_PU_L;
               state_in = S_PU_R;
            end
         end
         S_PU_R: begin
            cmd      = rast_pkg::CMD_PU_R;
            state_in = S_PU_W;
         end
         S_PU_W: begin
            cmd      = rast_pkg::CMD_PU_W;
            state_in = S_RET;
         end
         S_OUT: begin
            if (!rsp_stall)
               state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
      if (csr_wr_en)
         state_in = S_CLEAR;
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= S_CLEAR;
      else
         state_ff <= state_in;
   end

endmodule

`default_nettype wire

/* rtl/range_add_range_sum_tree.sv */
// ---------------------------------------------------------------------------
// Range add / range sum lazy segment tree
// Set one position, add to a range, or return the wrapped sum of a range.
// ---------------------------------------------------------------------------
//   port group | dir | word
//   req_       | in  | action, range_low, range_high, operand_value
//   rsp_       | out | range_sum (sum words only)
//   csr_       | in  | active_length, write only
//
// One word at a time. A visited node is read; one with a pending tag pushes it
// to both children before descending. A stack unwind pops a frame; set/add
// then pull up the sums of both children. The single-port node memories bound
// the pace. After reset and after every csr write a clearing pass over all
// 4*MAX_POSITIONS node slots runs with req_stall high. A sum result holds on
// rsp_ until taken; no new word is taken meanwhile.
`default_nettype none

`include "range_add_range_sum_tree_macros.svh"

module range_add_range_sum_tree #(
   parameter int MAX_POSITIONS = 1024,
   parameter int VALUE_WIDTH   = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_action,
   input  logic [$clog2(MAX_POSITIONS)-1:0]      req_range_low,
   input  logic [$clog2(MAX_POSITIONS+1)-1:0]    req_range_high,
   input  logic signed [63:0]                    req_operand_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [63:0]                    rsp_range_sum,
   input  logic                                  csr_wr_en,
   input  logic [$clog2(MAX_POSITIONS+1)-1:0]    csr_wr_data
);

   rast_pkg::cmd_type    cmd;
   rast_pkg::status_type status;

   rast_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .status     (status)
   );

   rast_dp #(
      .MAX_POSITIONS (MAX_POSITIONS),
      .VALUE_WIDTH   (VALUE_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_action        (req_action),
      .req_range_low     (req_range_low),
      .req_range_high    (req_range_high),
      .req_operand_value (req_operand_value),
      .rsp_range_sum     (rsp_range_sum)
   );

   // taking a word implies no result is still pending
   `RAST_ASSERT_IMPL(a_idle_no_rsp, clock, reset, !req_stall, !rsp_valid)
   `RAST_ASSERT_NEXT(a_rsp_once, clock, reset, rsp_valid && !rsp_stall, !rsp_valid)
   `RAST_ASSERT_NEXT(a_csr_clears, clock, reset, csr_wr_en, req_stall && !rsp_valid)

endmodule

`default_nettype wire
